// File: design/wnpip_pkg.sv
// Package for the winding-number point-in-polygon core.
// Holds the item structs, the inter-stage structs and the crossing codes.
// No dependencies.
package wnpip_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int WIND_W  = 13;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      first_vertex;
    logic                      last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [WIND_W-1:0] winding;
    logic                     on_edge;
    logic                     is_inside;
  } out_item_t;

  // segment ends relative to the test point
  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     last;
    logic signed [DIFF_W-1:0] ax;
    logic signed [DIFF_W-1:0] ay;
    logic signed [DIFF_W-1:0] bx;
    logic signed [DIFF_W-1:0] by;
  } seg_t;

  typedef struct packed {
    logic neg;
    logic pos;
  } sgn_t;

  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     last;
    sgn_t                     sax;
    sgn_t                     say;
    sgn_t                     sbx;
    sgn_t                     sby;
    logic signed [PROD_W-1:0] cross_l;
    logic signed [PROD_W-1:0] cross_r;
  } prod_t;

  typedef enum logic [2:0] {
    CR_NONE,
    CR_UP_HALF,
    CR_DN_HALF,
    CR_UP_FULL,
    CR_DN_FULL,
    CR_EDGE
  } cross_t;

endpackage

// File: design/wnpip_front.sv
// Input stage: holds the test point and previous vertex, registers the
// segment ends moved to the point's origin. Depends on wnpip_pkg.
module wnpip_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              in_valid,
  input  wnpip_pkg::in_item_t in_data,
  output wnpip_pkg::seg_t   seg_r
);
  import wnpip_pkg::*;

  logic signed [COORD_W-1:0] held_x_r, held_y_r, prev_x_r, prev_y_r;
  seg_t seg_nxt;

  always_comb begin
    seg_nxt       = seg_r;
    seg_nxt.valid = in_valid;
    seg_nxt.first = in_data.first_vertex;
    seg_nxt.last  = in_data.last_vertex;
    seg_nxt.ax    = {prev_x_r[COORD_W-1], prev_x_r} - {held_x_r[COORD_W-1], held_x_r};
    seg_nxt.ay    = {prev_y_r[COORD_W-1], prev_y_r} - {held_y_r[COORD_W-1], held_y_r};
    seg_nxt.bx    = {in_data.vertex_x[COORD_W-1], in_data.vertex_x}
                  - {held_x_r[COORD_W-1], held_x_r};
    seg_nxt.by    = {in_data.vertex_y[COORD_W-1], in_data.vertex_y}
                  - {held_y_r[COORD_W-1], held_y_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r    <= '0;
      held_y_r    <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      seg_r       <= '0;
    end else if (advance) begin
      seg_r <= seg_nxt;
      if (in_valid) begin
        if (in_data.first_vertex) begin
          held_x_r <= in_data.point_x;
          held_y_r <= in_data.point_y;
        end
        prev_x_r <= in_data.vertex_x;
        prev_y_r <= in_data.vertex_y;
      end
    end
  end

endmodule

// File: design/wnpip_cross.sv
// Product stage: the two cross products of the segment ends and the
// sign flags of each coordinate. Depends on wnpip_pkg.
module wnpip_cross (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  wnpip_pkg::seg_t seg_r,
  output wnpip_pkg::prod_t prod_r
);
  import wnpip_pkg::*;

  prod_t prod_nxt;

  function automatic sgn_t sign_of(logic signed [DIFF_W-1:0] v);
    sgn_t s;
    s.neg = v[DIFF_W-1];
    s.pos = !v[DIFF_W-1] && (v != '0);
    return s;
  endfunction

  always_comb begin
    prod_nxt.valid   = seg_r.valid;
    prod_nxt.first   = seg_r.first;
    prod_nxt.last    = seg_r.last;
    prod_nxt.sax     = sign_of(seg_r.ax);
    prod_nxt.say     = sign_of(seg_r.ay);
    prod_nxt.sbx     = sign_of(seg_r.bx);
    prod_nxt.sby     = sign_of(seg_r.by);
    prod_nxt.cross_l = seg_r.ax * seg_r.by;
    prod_nxt.cross_r = seg_r.bx * seg_r.ay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
    end else if (advance) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// File: design/wnpip_accum.sv
// Final stage: classifies the segment, accumulates the crossing sum with
// saturation and the sticky on-edge flag, and holds the result register.
// Depends on wnpip_pkg.
module wnpip_accum #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  wnpip_pkg::prod_t     prod_r,
  input  logic                 out_ready,
  output logic                 out_valid,
  output wnpip_pkg::out_item_t out_data
);
  import wnpip_pkg::*;

  localparam int SW = $clog2(2 * MAX_VERTICES) + 1;
  localparam int WW = (SW > WIND_W) ? SW : WIND_W;
  localparam logic signed [SW:0] LIM = (SW+1)'(2 * MAX_VERTICES - 1);

  logic signed [SW-1:0] sum_r, sum_nxt;
  logic                 edge_r, edge_nxt;
  cross_t               code;
  logic signed [2:0]    delta;
  logic signed [SW:0]   sum_add;
  logic signed [WW-1:0] wide_sum, rounded, half;
  logic                 y_same, x_same, y_zero, eq;
  logic                 out_valid_r;
  out_item_t            out_data_r, out_nxt;

  always_comb begin
    y_same = (prod_r.say.pos && prod_r.sby.pos) || (prod_r.say.neg && prod_r.sby.neg);
    x_same = (prod_r.sax.pos && prod_r.sbx.pos) || (prod_r.sax.neg && prod_r.sbx.neg);
    y_zero = !(prod_r.say.pos || prod_r.say.neg) || !(prod_r.sby.pos || prod_r.sby.neg);
    eq     = prod_r.cross_l == prod_r.cross_r;
    if (y_same) begin
      code = CR_NONE;
    end else if (eq && !x_same) begin
      code = CR_EDGE;
    end else if (y_zero) begin
      if (!(prod_r.sby.pos || prod_r.sby.neg)) begin
        // segment ends on the axis
        if (!(prod_r.say.pos || prod_r.say.neg) || prod_r.sbx.pos) begin
          code = CR_NONE;
        end else begin
          code = prod_r.say.pos ? CR_DN_HALF : CR_UP_HALF;
        end
      end else if (prod_r.sax.pos) begin
        code = CR_NONE;
      end else begin
        code = prod_r.sby.pos ? CR_UP_HALF : CR_DN_HALF;
      end
    end else if (prod_r.say.neg) begin
      code = (prod_r.cross_l >= prod_r.cross_r) ? CR_NONE : CR_UP_FULL;
    end else begin
      code = (prod_r.cross_r >= prod_r.cross_l) ? CR_NONE : CR_DN_FULL;
    end
  end

  always_comb begin
    case (code)
      CR_UP_HALF: delta = 3'sd1;
      CR_DN_HALF: delta = -3'sd1;
      CR_UP_FULL: delta = 3'sd2;
      CR_DN_FULL: delta = -3'sd2;
      default:    delta = 3'sd0;
    endcase
    sum_add  = {sum_r[SW-1], sum_r} + (SW+1)'(delta);
    sum_nxt  = sum_r;
    edge_nxt = edge_r;
    if (prod_r.first) begin
      sum_nxt  = '0;
      edge_nxt = 1'b0;
    end else if (!edge_r) begin
      if (code == CR_EDGE) begin
        edge_nxt = 1'b1;
      end else if (sum_add > LIM) begin
        sum_nxt = LIM[SW-1:0];
      end else if (sum_add < -LIM) begin
        sum_nxt = SW'(-LIM);
      end else begin
        sum_nxt = sum_add[SW-1:0];
      end
    end
    // halve toward zero
    wide_sum = WW'(sum_nxt);
    rounded  = wide_sum + {{(WW-1){1'b0}}, wide_sum[WW-1]};
    half     = rounded >>> 1;
    out_nxt.winding   = edge_nxt ? '0 : half[WIND_W-1:0];
    out_nxt.on_edge   = edge_nxt;
    out_nxt.is_inside = !edge_nxt && (half != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      edge_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance && prod_r.valid) begin
        sum_r  <= sum_nxt;
        edge_r <= edge_nxt;
      end
      if (advance && prod_r.valid && prod_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && prod_r.valid && prod_r.last) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_r <= $signed(LIM[SW-1:0])) && (sum_r >= SW'(-LIM)))
    else $error("crossing sum out of range");

  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.on_edge |-> (out_data_r.winding == '0) && !out_data_r.is_inside)
    else $error("on-edge result with nonzero winding");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(advance && prod_r.valid && prod_r.last))
    else $error("result register overwritten while stalled");

  a_edge_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    edge_r && !(advance && prod_r.valid && prod_r.first) |=> edge_r)
    else $error("on-edge flag cleared mid-polygon");

endmodule

// File: design/winding_number_point_in_polygon_core.sv
// Top level of the winding-number point-in-polygon core.
// Instantiates wnpip_front, wnpip_cross and wnpip_accum; uses wnpip_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one polygon vertex per
//   item. first_vertex latches the test point and clears the count;
//   last_vertex must repeat the first vertex and makes one result item.
//   Result channel (out_valid/out_ready/out_data) gives winding, on_edge
//   and is_inside for each polygon.
// Timing:
//   One vertex per cycle sustained while not stalled. Three register
//   stages (segment ends, cross products, accumulate/result); the last
//   one is the result register that drives the out_data port.
//   The pipeline stalls only when a last-vertex item reaches the final
//   stage while the result register is still held by the receiver; other
//   vertices keep flowing while a result waits.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline and clears the
//   held point, previous vertex, crossing sum and on-edge flag to zero.
module winding_number_point_in_polygon_core #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wnpip_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wnpip_pkg::out_item_t out_data
);
  import wnpip_pkg::*;

  seg_t  seg_r;
  prod_t prod_r;
  logic  advance;

  // hold everything only when a result would land on a stalled one
  assign advance  = !(prod_r.valid && prod_r.last && out_valid && !out_ready);
  assign in_ready = advance;

  wnpip_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_valid (in_valid),
    .in_data  (in_data),
    .seg_r    (seg_r)
  );

  wnpip_cross u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .seg_r   (seg_r),
    .prod_r  (prod_r)
  );

  wnpip_accum #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .prod_r    (prod_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

endmodule
